@@ rtl/kana_script_converter_assert.svh @@
// Assertion macros for the kana script converter; empty under synthesis.
`ifndef KANA_SCRIPT_CONVERTER_ASSERT_SVH
`define KANA_SCRIPT_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define KSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("kscv check failed");
`define KSC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kscv check failed");
`else
`define KSC_ASSERT(lbl, clk, rst, prop)
`define KSC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ rtl/kscv_pkg.sv @@
// Shared types, constants and kana lookup functions for the kana script converter.
package kscv_pkg;

  localparam int CP_W = 21;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_K2H  = 2'd1;
  localparam logic [1:0] MODE_H2K  = 2'd2;

  localparam logic [CP_W-1:0] SMALL_KA       = 21'h030F5;
  localparam logic [CP_W-1:0] SMALL_KE       = 21'h030F6;
  localparam logic [CP_W-1:0] PROLONGED_MARK = 21'h030FC;
  localparam logic [CP_W-1:0] HIRA_FIRST     = 21'h03041;
  localparam logic [CP_W-1:0] HIRA_LAST      = 21'h03096;
  localparam logic [CP_W-1:0] KATA_FIRST     = 21'h030A1;
  localparam logic [CP_W-1:0] KATA_LAST      = 21'h030F6;
  localparam logic [CP_W-1:0] KATA_VU        = 21'h030F4;
  localparam logic [CP_W-1:0] KATA_VA        = 21'h030F7;
  localparam logic [CP_W-1:0] KATA_VI        = 21'h030F8;
  localparam logic [CP_W-1:0] KATA_VE        = 21'h030F9;
  localparam logic [CP_W-1:0] KATA_VO        = 21'h030FA;
  localparam logic [CP_W-1:0] KANA_SHIFT     = 21'h00060;
  localparam int              SYLLABLE_COUNT = 82;

  localparam logic [CP_W-1:0] HIRA_A = 21'h03042;
  localparam logic [CP_W-1:0] HIRA_I = 21'h03044;
  localparam logic [CP_W-1:0] HIRA_U = 21'h03046;
  localparam logic [CP_W-1:0] HIRA_E = 21'h03048;

  localparam logic [2:0] VOWEL_NONE = 3'd0;
  localparam logic [2:0] VOWEL_A    = 3'd1;
  localparam logic [2:0] VOWEL_I    = 3'd2;
  localparam logic [2:0] VOWEL_U    = 3'd3;
  localparam logic [2:0] VOWEL_E    = 3'd4;
  localparam logic [2:0] VOWEL_O    = 3'd5;

  localparam int SYL_IDX_W = $clog2(SYLLABLE_COUNT);

  localparam logic [2:0] SYLLABLE_VOWEL [SYLLABLE_COUNT] = '{
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd3, 3'd3, 3'd5, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd2, 3'd4, 3'd5
  };

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            string_start;
  } kscv_item_t;

  // Vowel class of a code point, from the fixed kana table.
  function automatic logic [2:0] vowel_of(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] hoff;
    logic [CP_W-1:0] koff;
    logic [2:0]      v;
    hoff = c - HIRA_FIRST;
    koff = c - KATA_FIRST;
    v    = VOWEL_NONE;
    if (c >= HIRA_FIRST && hoff < CP_W'(SYLLABLE_COUNT)) begin
      v = SYLLABLE_VOWEL[hoff[SYL_IDX_W-1:0]];
    end else if (c >= KATA_FIRST && koff < CP_W'(SYLLABLE_COUNT)) begin
      v = SYLLABLE_VOWEL[koff[SYL_IDX_W-1:0]];
    end else if (c == KATA_VU) begin
      v = VOWEL_U;
    end else if (c == SMALL_KA || c == KATA_VA) begin
      v = VOWEL_A;
    end else if (c == SMALL_KE || c == KATA_VE) begin
      v = VOWEL_E;
    end else if (c == KATA_VI) begin
      v = VOWEL_I;
    end else if (c == KATA_VO) begin
      v = VOWEL_O;
    end
    return v;
  endfunction

endpackage

@@ rtl/kscv_in_if.sv @@
// Input channel: one code point and its string start flag per beat.
interface kscv_in_if;
  import kscv_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            string_start;

  modport source (output valid, output code_point, output string_start, input ready);
  modport sink (input valid, input code_point, input string_start, output ready);
endinterface

@@ rtl/kscv_out_if.sv @@
// Output channel: one converted code point per beat.
interface kscv_out_if;
  import kscv_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] converted_point;

  modport source (output valid, output converted_point, input ready);
  modport sink (input valid, input converted_point, output ready);
endinterface

@@ rtl/kana_script_converter.sv @@
// Kana script converter: top level with mode register and output register.
//
// Usage:
//   in_ch  carries one Unicode code point and a string start flag per beat;
//          a beat moves when valid and ready are both high.
//   out_ch carries one converted code point per accepted input beat, in order.
//   cfg_we/cfg_wdata write the conversion mode (0 pass, 1 katakana to
//   hiragana, 2 hiragana to katakana, 3 pass); write only while idle.
// Path: an accepted beat is held in the input register, then converted into
//   the output register that drives out_ch. Throughput: one beat per cycle
//   while out_ch is not stalled; the single dependency from one character to
//   the next is the 3-bit vowel register, updated as each converted beat advances.
// Reset (rst, synchronous): both pipeline stages empty, mode 0, no previous
//   character remembered.
// Receiver stall: the output register holds its beat; the input register
//   still takes one more beat, after which in_ch.ready drops until out_ch
//   drains.
module kana_script_converter
  import kscv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kscv_in_if.sink    in_ch,
  kscv_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

`include "kana_script_converter_assert.svh"

  logic            conversion_mode;
  logic [1:0]      mode_q;
  kscv_item_t      item;
  logic            item_valid;
  logic            advance;
  logic [CP_W-1:0] result;
  logic            out_valid_q;
  logic [CP_W-1:0] out_data_q;

  assign conversion_mode = cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_PASS;
    end else if (conversion_mode) begin
      mode_q <= cfg_wdata;
    end
  end

  assign advance = item_valid && (!out_valid_q || out_ch.ready);

  kscv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  kscv_core u_core (
    .clk    (clk),
    .rst    (rst),
    .mode   (mode_q),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.converted_point = out_data_q;

  `KSC_ASSERT_NR(a_reset_empty, clk, $past(rst) |-> !out_valid_q)
  `KSC_ASSERT(a_result_lands, clk, rst, advance |=> out_valid_q)
  `KSC_ASSERT(a_no_overwrite, clk, rst, (out_valid_q && !out_ch.ready) |-> !advance)

endmodule

@@ rtl/kscv_in_stage.sv @@
// Input register stage: captures one beat and holds it until the core takes it.
module kscv_in_stage
  import kscv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kscv_in_if.sink    in_ch,
  input  logic       advance,
  output kscv_item_t item,
  output logic       item_valid
);

  logic       valid_q;
  kscv_item_t item_q;

  assign in_ch.ready = !valid_q || advance;
  assign item        = item_q;
  assign item_valid  = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_q.code_point   <= in_ch.code_point;
      item_q.string_start <= in_ch.string_start;
    end
  end

endmodule

@@ rtl/kscv_core.sv @@
// Conversion logic and the previous-character vowel register.
module kscv_core
  import kscv_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      mode,
  input  logic            fire,
  input  kscv_item_t      item,
  output logic [CP_W-1:0] result
);

`include "kana_script_converter_assert.svh"

  logic [2:0]      previous_vowel;
  logic [2:0]      prev_eff;
  logic [CP_W-1:0] c;
  logic [CP_W-1:0] r;

  assign c        = item.code_point;
  assign prev_eff = item.string_start ? VOWEL_NONE : previous_vowel;

  always_comb begin
    r = c;
    unique case (mode)
      MODE_K2H: begin
        if (c == SMALL_KA || c == SMALL_KE) begin
          r = c;
        end else if (c == PROLONGED_MARK) begin
          unique case (prev_eff)
            VOWEL_A: r = HIRA_A;
            VOWEL_I: r = HIRA_I;
            VOWEL_U: r = HIRA_U;
            VOWEL_E: r = HIRA_E;
            VOWEL_O: r = HIRA_U;   // o vowel lengthens with u
            default: r = c;
          endcase
        end else if (c >= KATA_FIRST && c <= KATA_LAST) begin
          r = c - KANA_SHIFT;
        end
      end
      MODE_H2K: begin
        if (c >= HIRA_FIRST && c <= HIRA_LAST) begin
          r = c + KANA_SHIFT;
        end
      end
      default: r = c;
    endcase
  end

  assign result = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_vowel <= VOWEL_NONE;
    end else if (fire) begin
      previous_vowel <= vowel_of(r);
    end
  end

  `KSC_ASSERT(a_k2h_no_kata, clk, rst, (fire && mode == MODE_K2H) |-> !(r >= KATA_FIRST && r <= KATA_VU))
  `KSC_ASSERT(a_h2k_no_hira, clk, rst, (fire && mode == MODE_H2K) |-> !(r >= HIRA_FIRST && r <= HIRA_LAST))
  `KSC_ASSERT(a_start_clears, clk, rst, (fire && item.string_start && mode == MODE_K2H && c == PROLONGED_MARK) |-> (r == PROLONGED_MARK))

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the kana script converter: directed table, then random phases.
module testbench;
  import kscv_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         LONG_HOLD   = 300;

  typedef struct packed {
    logic [1:0]      mode;
    logic [CP_W-1:0] cp;
    logic            st;
    logic            typed;
    logic [CP_W-1:0] want;
  } kana_row_t;

  // typed = 1: the expected code point is given in the row
  localparam kana_row_t DIRECTED_ROWS [27] = '{
    '{MODE_PASS,  21'h030A2, 1'b1, 1'b1, 21'h030A2},
    '{MODE_PASS,  21'h1FFFFF, 1'b0, 1'b1, 21'h1FFFFF},
    '{MODE_PASS,  21'h000000, 1'b0, 1'b1, 21'h000000},
    '{MODE_K2H,   21'h030FC, 1'b1, 1'b1, 21'h030FC},
    '{MODE_K2H,   21'h030A1, 1'b0, 1'b1, 21'h03041},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b1, 21'h03042},
    '{MODE_K2H,   21'h030F6, 1'b0, 1'b1, 21'h030F6},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b1, 21'h03048},
    '{MODE_K2H,   21'h030F5, 1'b0, 1'b1, 21'h030F5},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b1, 21'h03042},
    '{MODE_K2H,   21'h030AA, 1'b0, 1'b1, 21'h0304A},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b1, 21'h03046},
    '{MODE_K2H,   21'h030F3, 1'b0, 1'b1, 21'h03093},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b1, 21'h030FC},
    '{MODE_K2H,   21'h030B5, 1'b0, 1'b0, 21'h000000},
    '{MODE_K2H,   21'h030FC, 1'b1, 1'b1, 21'h030FC},
    '{MODE_K2H,   21'h030F9, 1'b0, 1'b1, 21'h030F9},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b0, 21'h000000},
    '{MODE_K2H,   21'h10FFFF, 1'b0, 1'b1, 21'h10FFFF},
    '{MODE_H2K,   21'h03041, 1'b1, 1'b1, 21'h030A1},
    '{MODE_H2K,   21'h03096, 1'b0, 1'b1, 21'h030F6},
    '{MODE_H2K,   21'h03040, 1'b0, 1'b1, 21'h03040},
    '{MODE_H2K,   21'h03046, 1'b0, 1'b1, 21'h030A6},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b0, 21'h000000},
    '{MODE_SPARE, 21'h03041, 1'b0, 1'b1, 21'h03041},
    '{MODE_SPARE, 21'h030A4, 1'b0, 1'b1, 21'h030A4},
    '{MODE_K2H,   21'h030FC, 1'b0, 1'b0, 21'h000000}
  };

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  kscv_in_if  in_ch ();
  kscv_out_if out_ch ();

  kana_script_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [1:0]      kana_mode;
  logic [2:0]      last_vowel;
  logic [CP_W-1:0] expected_points [$];

  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] vowel_class(input logic [CP_W-1:0] c);
    if (c >= HIRA_FIRST && c < HIRA_FIRST + SYLLABLE_COUNT) begin
      return SYLLABLE_VOWEL[int'(c - HIRA_FIRST)];
    end
    if (c >= KATA_FIRST && c < KATA_FIRST + SYLLABLE_COUNT) begin
      return SYLLABLE_VOWEL[int'(c - KATA_FIRST)];
    end
    case (c)
      KATA_VU:           return VOWEL_U;
      SMALL_KA, KATA_VA: return VOWEL_A;
      SMALL_KE, KATA_VE: return VOWEL_E;
      KATA_VI:           return VOWEL_I;
      KATA_VO:           return VOWEL_O;
      default:           return VOWEL_NONE;
    endcase
  endfunction

  // o vowel lengthens with u
  function automatic logic [CP_W-1:0] long_vowel(input logic [2:0] v,
                                                 input logic [CP_W-1:0] mark);
    case (v)
      VOWEL_A:          return HIRA_A;
      VOWEL_I:          return HIRA_I;
      VOWEL_U, VOWEL_O: return HIRA_U;
      VOWEL_E:          return HIRA_E;
      default:          return mark;
    endcase
  endfunction

  function automatic logic [CP_W-1:0] convert_kana(input logic [CP_W-1:0] cp,
                                                   input logic st);
    logic [CP_W-1:0] res;
    res = cp;
    if (st) last_vowel = VOWEL_NONE;
    case (kana_mode)
      MODE_K2H: begin
        if (cp == SMALL_KA || cp == SMALL_KE) begin
          res = cp;
        end else if (cp == PROLONGED_MARK) begin
          res = long_vowel(last_vowel, cp);
        end else if (cp >= KATA_FIRST && cp <= KATA_LAST) begin
          res = cp - KANA_SHIFT;
        end
      end
      MODE_H2K: begin
        if (cp >= HIRA_FIRST && cp <= HIRA_LAST) res = cp + KANA_SHIFT;
      end
      default: ;
    endcase
    // memory follows the output in every mode
    last_vowel = vowel_class(res);
    return res;
  endfunction

  function automatic void check_beat(input logic [CP_W-1:0] got);
    logic [CP_W-1:0] want;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      fail_count++;
    end else begin
      want = expected_points.pop_front();
      if (got !== want) begin
        $display("%0t: converted_point expected %h actual %h", $time, want, got);
        fail_count++;
      end
    end
  endfunction

  // Offers one beat after a random gap; returns once it has been taken.
  task automatic send_beat(input logic [CP_W-1:0] cp, input logic st,
                           input logic typed, input logic [CP_W-1:0] want);
    logic [CP_W-1:0] predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.code_point   <= cp;
    in_ch.string_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    predicted = convert_kana(cp, st);
    expected_points.push_back(typed ? want : predicted);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    kana_mode = m;
  endtask

  // Mostly kana and prolonged marks so the vowel memory gets exercised.
  task automatic send_random_beat;
    logic [CP_W-1:0] cp;
    int              pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      cp = CP_W'($urandom_range(32'h30A0, 32'h30FF));
    else if (pick < 70) cp = CP_W'($urandom_range(32'h3040, 32'h309F));
    else if (pick < 82) cp = PROLONGED_MARK;
    else if (pick < 92) cp = CP_W'($urandom_range(0, 32'h1FFFFF));
    else                cp = CP_W'($urandom_range(0, 32'h10FFFF));
    send_beat(cp, ($urandom_range(0, 9) == 0), 1'b0, '0);
  endtask

  // receiver: checks beats and throttles ready
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) check_beat(out_ch.converted_point);
      if (hold_request && !hold_taken) begin
        hold_taken = 1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** kana_script_converter: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 51, 0, 38};
    recv_pct = '{0, 0, 51, 38};
    fail_count         = 0;
    kana_mode          = MODE_PASS;
    last_vowel         = VOWEL_NONE;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_request       = 0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= MODE_PASS;
    in_ch.valid        <= 1'b0;
    in_ch.code_point   <= '0;
    in_ch.string_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].mode != kana_mode) begin
        drain();
        write_mode(DIRECTED_ROWS[i].mode);
      end
      send_beat(DIRECTED_ROWS[i].cp, DIRECTED_ROWS[i].st,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // each idling phase walks all four modes, starting at a different one
    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 4; m++) begin
        drain();
        send_idle_pct  = send_pct[p];
        recv_stall_pct <= recv_pct[p];
        write_mode(2'((p + m) % 4));
        repeat (30) send_random_beat();
      end
    end

    // receiver holds off while the sender keeps offering: input must back up
    drain();
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    write_mode(MODE_K2H);
    hold_request <= 1'b1;
    repeat (40) send_random_beat();

    drain();
    if (fail_count == 0) begin
      $display("** kana_script_converter: PASSED **");
    end else begin
      $display("** kana_script_converter: FAILED **");
    end
    $finish;
  end

endmodule
